// ----- rtl/jlh_pkg.sv -----
// ----------------------------------------------------------------------------
// jlh_pkg: shared types, constants and round functions
// Command format between the byte front end and the mix engine, plus the
// lookup3 mix and final-mix rounds.
// ----------------------------------------------------------------------------
package jlh_pkg;

  localparam logic [31:0] SEED_BASE   = 32'hdeadbeef;
  localparam int unsigned BLOCK_BYTES = 12;
  localparam logic [3:0]  BLOCK_FULL  = 4'd12;

  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pair-of-rounds schedule: last pair start index for each pass
  localparam logic [2:0] MIX_LAST_PAIR   = 3'd4;
  localparam logic [2:0] FINAL_LAST_PAIR = 3'd6;

  typedef enum logic [1:0] {
    CMD_MIX,
    CMD_FINAL,
    CMD_MIX_FINAL,
    CMD_EMPTY
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic        first;
    logic [31:0] seed;
    logic [95:0] block;
    logic [7:0]  tail;
  } cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_FINAL
  } back_state_e;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned k);
    return (v << k) | (v >> (32 - k));
  endfunction

  // One round of the block mix
  function automatic abc_t mix_step(input abc_t s, input logic [2:0] k);
    abc_t r;
    r = s;
    unique case (k)
      3'd0: begin
        r.a = (s.a - s.c) ^ rotl32(s.c, 4);
        r.c = s.c + s.b;
      end
      3'd1: begin
        r.b = (s.b - s.a) ^ rotl32(s.a, 6);
        r.a = s.a + s.c;
      end
      3'd2: begin
        r.c = (s.c - s.b) ^ rotl32(s.b, 8);
        r.b = s.b + s.a;
      end
      3'd3: begin
        r.a = (s.a - s.c) ^ rotl32(s.c, 16);
        r.c = s.c + s.b;
      end
      3'd4: begin
        r.b = (s.b - s.a) ^ rotl32(s.a, 19);
        r.a = s.a + s.c;
      end
      3'd5: begin
        r.c = (s.c - s.b) ^ rotl32(s.b, 4);
        r.b = s.b + s.a;
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // One round of the final mix; index seven passes through
  function automatic abc_t final_step(input abc_t s, input logic [2:0] k);
    abc_t r;
    r = s;
    unique case (k)
      3'd0: r.c = (s.c ^ s.b) - rotl32(s.b, 14);
      3'd1: r.a = (s.a ^ s.c) - rotl32(s.c, 11);
      3'd2: r.b = (s.b ^ s.a) - rotl32(s.a, 25);
      3'd3: r.c = (s.c ^ s.b) - rotl32(s.b, 16);
      3'd4: r.a = (s.a ^ s.c) - rotl32(s.c, 4);
      3'd5: r.b = (s.b ^ s.a) - rotl32(s.a, 14);
      3'd6: r.c = (s.c ^ s.b) - rotl32(s.b, 24);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/jlh_front.sv -----
// ----------------------------------------------------------------------------
// jlh_front: byte intake and block assembly
// Folds each byte when the path fold is on, gathers 12-byte blocks and issues mix and final commands.
// ----------------------------------------------------------------------------
module jlh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fold_path_i,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic [31:0]       total_length_i,
  input  logic              last_item_i,
  input  logic              no_byte_i,
  output logic              push_o,
  output jlh_pkg::cmd_t     cmd_o
);

  logic        in_string_q, in_string_d;
  logic        first_q, first_d;
  logic [31:0] seed_q, seed_d;
  logic [3:0]  slot_q, slot_d;
  logic [95:0] block_q, block_d;

  logic [7:0]  byte_f;
  logic        start;
  logic        first_now;
  logic [31:0] seed_now;
  logic [3:0]  slot_now;
  logic [95:0] block_now;
  logic [95:0] block_ins;
  logic        need_mix;

  always_comb begin
    byte_f = data_byte_i;
    if (fold_path_i) begin
      if (byte_f == jlh_pkg::CHAR_SLASH) byte_f = jlh_pkg::CHAR_BSLASH;
      if (byte_f >= jlh_pkg::CHAR_LOW_A && byte_f <= jlh_pkg::CHAR_LOW_Z) begin
        byte_f = byte_f - jlh_pkg::CASE_OFFSET;
      end
    end
  end

  assign start     = !in_string_q;
  assign first_now = start ? 1'b1 : first_q;
  assign seed_now  = start ? (jlh_pkg::SEED_BASE + total_length_i) : seed_q;
  assign slot_now  = start ? 4'd0 : slot_q;
  assign block_now = start ? '0 : block_q;
  assign need_mix  = !no_byte_i && (slot_now == jlh_pkg::BLOCK_FULL);

  // Drop the new byte into its slot
  always_comb begin
    for (int i = 0; i < jlh_pkg::BLOCK_BYTES; i++) begin
      block_ins[i*8 +: 8] = (slot_now == 4'(i)) ? byte_f : block_now[i*8 +: 8];
    end
  end

  always_comb begin
    in_string_d = in_string_q;
    first_d     = first_q;
    seed_d      = seed_q;
    slot_d      = slot_q;
    block_d     = block_q;
    push_o      = 1'b0;
    cmd_o.op    = jlh_pkg::CMD_MIX;
    cmd_o.first = first_now;
    cmd_o.seed  = seed_now;
    cmd_o.block = block_now;
    cmd_o.tail  = byte_f;

    if (accept_i && !(no_byte_i && !last_item_i)) begin
      in_string_d = 1'b1;
      seed_d      = seed_now;
      first_d     = first_now;
      slot_d      = slot_now;
      block_d     = block_now;
      if (!no_byte_i) begin
        if (need_mix) begin
          block_d = {88'd0, byte_f};
          slot_d  = 4'd1;
        end else begin
          block_d = block_ins;
          slot_d  = slot_now + 4'd1;
        end
      end

      if (last_item_i) begin
        push_o      = 1'b1;
        in_string_d = 1'b0;
        if (need_mix) begin
          cmd_o.op = jlh_pkg::CMD_MIX_FINAL;
        end else if (slot_d != 4'd0) begin
          cmd_o.op    = jlh_pkg::CMD_FINAL;
          cmd_o.block = block_d;
        end else begin
          cmd_o.op = jlh_pkg::CMD_EMPTY;
        end
      end else if (need_mix) begin
        push_o  = 1'b1;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      first_q     <= 1'b0;
      slot_q      <= 4'd0;
    end else begin
      in_string_q <= in_string_d;
      first_q     <= first_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q  <= seed_d;
    block_q <= block_d;
  end

endmodule

// ----- rtl/jlh_fifo.sv -----
// ----------------------------------------------------------------------------
// jlh_fifo: command queue
// Short queue between block assembly and the mix engine.
// ----------------------------------------------------------------------------
module jlh_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jlh_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output jlh_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PW = (jlh_pkg::QPTR_W > 0) ? jlh_pkg::QPTR_W : 1;
  localparam int unsigned CW = jlh_pkg::QCNT_W;

  jlh_pkg::cmd_t mem_q [jlh_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(jlh_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(jlh_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// ----- rtl/jlh_back.sv -----
// ----------------------------------------------------------------------------
// jlh_back: mix engine
// Runs two lookup3 rounds per cycle unless the result register is busy, and holds that register.
// ----------------------------------------------------------------------------
module jlh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jlh_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [63:0]   hash_value_o
);

  jlh_pkg::back_state_e state_q, state_d;
  jlh_pkg::abc_t        s_q, s_d;
  logic [2:0]           step_q, step_d;
  logic                 fin_pend_q, fin_pend_d;
  logic [7:0]           tail_q, tail_d;
  logic                 out_valid_q, out_valid_d;
  logic [63:0]          hash_q, hash_d;

  jlh_pkg::abc_t base, loaded, mix2, fin2;
  logic          out_free;
  logic [2:0]    step_nx;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step_nx  = step_q + 3'd1;

  always_comb begin
    base     = head_i.first ? {head_i.seed, head_i.seed, head_i.seed} : s_q;
    loaded.a = base.a + head_i.block[31:0];
    loaded.b = base.b + head_i.block[63:32];
    loaded.c = base.c + head_i.block[95:64];
    mix2     = jlh_pkg::mix_step(jlh_pkg::mix_step(s_q, step_q), step_nx);
    fin2     = jlh_pkg::final_step(jlh_pkg::final_step(s_q, step_q), step_nx);
  end

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    step_d      = step_q;
    fin_pend_d  = fin_pend_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    pop_o       = 1'b0;

    unique case (state_q)
      jlh_pkg::BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.op == jlh_pkg::CMD_EMPTY) begin
            if (out_free) begin
              pop_o       = 1'b1;
              out_valid_d = 1'b1;
              hash_d      = {head_i.seed, head_i.seed};
            end
          end else begin
            pop_o      = 1'b1;
            s_d        = loaded;
            step_d     = 3'd0;
            fin_pend_d = (head_i.op == jlh_pkg::CMD_MIX_FINAL);
            tail_d     = head_i.tail;
            state_d    = (head_i.op == jlh_pkg::CMD_FINAL) ? jlh_pkg::BK_FINAL
                                                           : jlh_pkg::BK_MIX;
          end
        end
      end
      jlh_pkg::BK_MIX: begin
        s_d    = mix2;
        step_d = step_q + 3'd2;
        if (step_q == jlh_pkg::MIX_LAST_PAIR) begin
          step_d = 3'd0;
          if (fin_pend_q) begin
            // Tail block holds a single byte in the low lane of a
            s_d.a   = mix2.a + {24'd0, tail_q};
            state_d = jlh_pkg::BK_FINAL;
          end else begin
            state_d = jlh_pkg::BK_IDLE;
          end
        end
      end
      jlh_pkg::BK_FINAL: begin
        if (step_q == jlh_pkg::FINAL_LAST_PAIR) begin
          // Hold the last pair until the result register frees up
          if (out_free) begin
            s_d         = fin2;
            hash_d      = {fin2.c, fin2.b};
            out_valid_d = 1'b1;
            state_d     = jlh_pkg::BK_IDLE;
          end
        end else begin
          s_d    = fin2;
          step_d = step_q + 3'd2;
        end
      end
      default: state_d = jlh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jlh_pkg::BK_IDLE;
      step_q      <= 3'd0;
      fin_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      fin_pend_q  <= fin_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    tail_q <= tail_d;
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// ----- rtl/jenkins_lookup3_path_hash.sv -----
// ----------------------------------------------------------------------------
// jenkins_lookup3_path_hash: streaming lookup3 (hashlittle2) byte hash
// Hashes a byte string, one byte per request, into the 64-bit value c:b,
// with an optional path fold (slash to backslash, ASCII upper case).
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | sink      | in_valid_i/in_stall_o   | data_byte, total_length,
//           |           |                     | last_item, no_byte
//  out      | source    | out_valid_o/out_stall_i | hash_value (c:b)
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | fold_path (cfg_data_i)
//
//  - The front end takes one byte request per cycle unless the queue is full.
//    Each full 12-byte block that is not the last is loaded at issue and then
//    mixed two rounds at a time, so long strings sustain one byte per cycle.
//  - The engine closes a string with the issue and the final-mix round pairs,
//    after the block-mix pairs when the last byte opens a new block; the empty
//    string needs only the issue. Short strings are thus paced by the mix engine, not by the byte intake.
//  - A two-entry command queue sits between intake and engine; intake stalls
//    only when it is full. While the previous hash still waits on
//    out_stall_i, the engine runs a final mix up to its last round pair and
//    holds there until the result register frees up.
//  - Reset clears all control state; fold_path resets to 0. No clearing pass.
//
module jenkins_lookup3_path_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] total_length_i,
  input  logic        last_item_i,
  input  logic        no_byte_i,
  // hash results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  logic          fold_path_q;
  logic          in_accept;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  jlh_pkg::cmd_t push_cmd;
  jlh_pkg::cmd_t head_cmd;

  // Config writes always land; the user must change the register only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_path_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fold_path_q <= cfg_data_i;
    end
  end

  // Stall intake whenever the queue could not take a command
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  jlh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fold_path_i    (fold_path_q),
    .accept_i       (in_accept),
    .data_byte_i    (data_byte_i),
    .total_length_i (total_length_i),
    .last_item_i    (last_item_i),
    .no_byte_i      (no_byte_i),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  jlh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  jlh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  // A command is never issued into a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into full queue");

  // The engine never takes a command from an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("command popped from empty queue");

  // A byteless request that does not end a string issues nothing
  a_skip_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && no_byte_i && !last_item_i) |-> !push)
    else $error("ignored request issued a command");

  // Every string end issues exactly one command in its cycle
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_item_i) |-> push)
    else $error("string end issued no command");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for jenkins_lookup3_path_hash
// Streams byte strings into the hash block under random idling on both
// channels. A scoreboard models the lookup3 state per request, queues the
// 64-bit c:b hash for every closed string and checks results in order.
// ----------------------------------------------------------------------------
module testbench;

  // Hold the receiver off this long to back the block up into its intake
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Quiet cycles with no handshake on any channel before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  // Settle headroom: longer than a final mix after a block mix
  localparam int unsigned SETTLE_CYCLES   = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: lookup3 state tracker plus the queue of predicted hashes
  // --------------------------------------------------------------------------
  class lookup3_scoreboard;
    localparam logic [31:0] SEED     = 32'hdeadbeef;
    localparam logic [7:0]  SLASH    = 8'h2F;
    localparam logic [7:0]  BSLASH   = 8'h5C;
    localparam logic [7:0]  LOWER_A  = 8'h61;
    localparam logic [7:0]  LOWER_Z  = 8'h7A;
    localparam int unsigned BLK_LEN  = 12;

    bit          fold_on;
    logic [31:0] ha, hb, hc;
    logic [7:0]  blk [BLK_LEN];
    int unsigned fill;
    bit          open;
    logic [63:0] pending_hashes [$];
    int unsigned mismatches;
    int unsigned hashes_checked;
    int unsigned strings_closed;
    int unsigned empty_strings;

    function new();
      fold_on = 1'b0;
      mismatches = 0;
      hashes_checked = 0;
      strings_closed = 0;
      empty_strings = 0;
      go_idle();
    endfunction

    function void go_idle();
      ha = '0;
      hb = '0;
      hc = '0;
      clear_block();
      fill = 0;
      open = 1'b0;
    endfunction

    function void clear_block();
      foreach (blk[i]) blk[i] = 8'h00;
    endfunction

    function logic [31:0] rot(logic [31:0] v, int unsigned k);
      return (v << k) | (v >> (32 - k));
    endfunction

    function logic [7:0] fold(logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (fold_on) begin
        if (r == SLASH) r = BSLASH;
        if (r >= LOWER_A && r <= LOWER_Z) r = r - 8'h20;
      end
      return r;
    endfunction

    // Add the gathered block as three little-endian words
    function void absorb();
      ha += {blk[3], blk[2], blk[1], blk[0]};
      hb += {blk[7], blk[6], blk[5], blk[4]};
      hc += {blk[11], blk[10], blk[9], blk[8]};
    endfunction

    function void block_rounds();
      ha -= hc; ha ^= rot(hc, 4);  hc += hb;
      hb -= ha; hb ^= rot(ha, 6);  ha += hc;
      hc -= hb; hc ^= rot(hb, 8);  hb += ha;
      ha -= hc; ha ^= rot(hc, 16); hc += hb;
      hb -= ha; hb ^= rot(ha, 19); ha += hc;
      hc -= hb; hc ^= rot(hb, 4);  hb += ha;
    endfunction

    function void final_rounds();
      hc ^= hb; hc -= rot(hb, 14);
      ha ^= hc; ha -= rot(hc, 11);
      hb ^= ha; hb -= rot(ha, 25);
      hc ^= hb; hc -= rot(hb, 16);
      ha ^= hc; ha -= rot(hc, 4);
      hb ^= ha; hb -= rot(ha, 14);
      hc ^= hb; hc -= rot(hb, 24);
    endfunction

    // Advance the model by one accepted byte request
    function void take_request(logic [7:0] d, logic [31:0] len, bit last, bit none);
      if (none && !last) return;
      if (!open) begin
        ha = SEED + len;
        hb = ha;
        hc = ha;
        clear_block();
        fill = 0;
        open = 1'b1;
      end
      if (!none) begin
        // a further byte proves the full block is not the last one
        if (fill == BLK_LEN) begin
          absorb();
          block_rounds();
          clear_block();
          fill = 0;
        end
        blk[fill] = fold(d);
        fill++;
      end
      if (!last) return;
      if (fill != 0) begin
        absorb();
        final_rounds();
      end else begin
        empty_strings++;
      end
      pending_hashes.push_back({hc, hb});
      strings_closed++;
      go_idle();
    endfunction

    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash result %016h", got);
        return;
      end
      want = pending_hashes.pop_front();
      hashes_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hash mismatch: expected %016h, got %016h", want, got);
      end
    endfunction

    function int unsigned pending();
      return pending_hashes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i     = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic [31:0] total_length_i = 32'h0;
  logic        last_item_i    = 1'b0;
  logic        no_byte_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [63:0] hash_value_o;

  jenkins_lookup3_path_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .total_length_i (total_length_i),
    .last_item_i    (last_item_i),
    .no_byte_i      (no_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o)
  );

  lookup3_scoreboard sb = new();

  bit          src_eager    = 1'b0;  // sender idles not at all while set
  bit          sink_eager   = 1'b0;  // receiver draws no random stall while set
  bit          hold_off_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned byte_reqs    = 0;     // requests the block acts on
  int unsigned noise_reqs   = 0;     // no-byte, not-last requests it drops
  int unsigned cfg_writes   = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, 10);
  endfunction

  // Half path-like characters so the fold sees slashes and letters often
  function automatic logic [7:0] pick_byte();
    string path_chars;
    path_chars = "/\\aAzZ`{@[mq._-09";
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return path_chars[$urandom_range(0, path_chars.len() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one request after a random gap, hold it until accepted
  // --------------------------------------------------------------------------
  task automatic send_request(logic [7:0] d, logic [31:0] len, bit last, bit none);
    int unsigned gap;
    gap = draw_gap(src_eager);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= d;
    total_length_i <= len;
    last_item_i    <= last;
    no_byte_i      <= none;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(d, len, last, none);
    if (none && !last) noise_reqs++;
    else byte_reqs++;
  endtask

  // Send one string; length only counts on the first real byte, so scramble it later
  task automatic send_string(int unsigned nbytes, logic [31:0] len, bit tail_none);
    bit ends_here;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(8'($urandom()), $urandom(), 1'b0, 1'b1);
      ends_here = (i == nbytes - 1) && !tail_none;
      send_request(pick_byte(), (i == 0) ? len : $urandom(), ends_here, 1'b0);
    end
    if (nbytes == 0 || tail_none)
      send_request(8'($urandom()), (nbytes == 0) ? len : $urandom(), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write fold_path only with the block idle and the engine settled
  task automatic write_fold(bit value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.fold_on = value;
    cfg_writes++;
  endtask

  // Mostly short strings around the 12-byte block edge, a few long ones
  task automatic run_random(int unsigned quota);
    int unsigned start;
    int unsigned nbytes;
    logic [31:0] len;
    bit          tail_none;
    start = byte_reqs;
    while (byte_reqs - start < quota) begin
      nbytes    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                              : $urandom_range(0, 14);
      len       = ($urandom_range(0, 4) == 0) ? $urandom() : nbytes;
      tail_none = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) src_eager = ~src_eager;
      send_string(nbytes, len, tail_none);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check every accepted hash, then draw the stall for the next one
  // --------------------------------------------------------------------------
  initial begin : hash_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_hash(hash_value_o);
        if ($urandom_range(0, 9) == 0) sink_eager = ~sink_eager;
        stall_left = draw_gap(sink_eager);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles, %0d hashes outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    string path;
    path = "/aZz`{\\@[/mq";

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fold off: empty strings at both length extremes, a dropped request
    // while idle, and single bytes at both byte extremes
    write_fold(1'b0);
    send_request(8'h00, 32'h0000_0000, 1'b1, 1'b1);
    send_request(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(8'hA5, 32'h1234_5678, 1'b0, 1'b1);
    send_request(8'hFF, 32'd1, 1'b1, 1'b0);
    send_request(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0);

    // Fold on: one exact block of path characters closed by a no-byte last
    // request, then a short string with a wrong length and a dropped request
    write_fold(1'b1);
    for (int i = 0; i < 12; i++)
      send_request(path[i], (i == 0) ? 32'd12 : $urandom(), 1'b0, 1'b0);
    send_request(8'h00, $urandom(), 1'b1, 1'b1);
    send_request("a", 32'd7, 1'b0, 1'b0);
    send_request(8'h3C, $urandom(), 1'b0, 1'b1);
    send_request("/", $urandom(), 1'b1, 1'b0);

    // Random phases, alternating the fold; back the block up in the first
    write_fold(1'b0);
    run_random(60);
    hold_off_req = 1'b1;
    run_random(300);

    // Pause the sender halfway until every hash has come back
    write_fold(1'b1);
    run_random(180);
    wait_drained();
    run_random(180);

    write_fold(1'b0);
    run_random(360);

    write_fold(1'b1);
    run_random(370);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d byte requests and %0d dropped ones in %0d strings (%0d empty)",
             byte_reqs, noise_reqs, sb.strings_closed, sb.empty_strings);
    $display("checked %0d hashes over %0d fold writes, %0d mismatches",
             sb.hashes_checked, cfg_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
